>>> rtl/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg: shared types and constants for the lifo stack with reverse
// Command and status codes, sequencer states, default sizes and port widths.
// ----------------------------------------------------------------------------
package lsr_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int WORD_BITS_DEF = 32;

	localparam int CMD_W       = 3;
	localparam int VALUE_W     = 32;
	localparam int DATA_W      = 32;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 7;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 40;
	localparam int M_TDATA_PAD = M_TDATA_W - DATA_W - COUNT_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH    = 3'd0,
		CMD_POP     = 3'd1,
		CMD_PEEK    = 3'd2,
		CMD_DUMP    = 3'd3,
		CMD_REVERSE = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP_RD,
		S_DUMP_OUT,
		S_REV_A,
		S_REV_B,
		S_REV_C,
		S_REV_D,
		S_DONE
	} state_t;

endpackage

>>> rtl/lifo_stack_with_reverse_core.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_reverse_core: bounded lifo stack of signed words
// Push, pop, peek, dump from bottom to top, and in-place reversal, all
// served by one ram port pair and one pointer step/compare unit.
// ----------------------------------------------------------------------------
//
// channel  dir  tdata                             tuser        tlast
// s_axis   in   push_value[31:0]                  command[2:0] -
// m_axis   out  data_word[31:0] entry_count[38:32] status[1:0] last
//
// push, pop, peek: accept, then one ram read or write
// dump: per entry, a registered ram read (S_DUMP_RD), then an output beat (S_DUMP_OUT)
// reverse: per swapped pair, two reads then two writes on one port pair
// reset clears the entry count and control state only; ram contents stay
// a stalled result holds in the output register and the sequencer waits for it
//
module lifo_stack_with_reverse_core
	import lsr_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // push_value[31:0]
	input  logic [CMD_W-1:0]     s_axis_tuser,  // command[2:0]

	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // data_word[31:0], entry_count[38:32], zero pad
	output logic [STATUS_W-1:0]  m_axis_tuser,  // status[1:0]
	output logic                 m_axis_tlast
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [CMD_W-1:0]     cmd_q;
	logic [VALUE_W-1:0]   val_q;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [AW-1:0]        ptr_q, lo_q, hi_q;
	logic [WORD_BITS-1:0] tmp_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

	logic                 m_valid_q;
	logic [DATA_W-1:0]    m_data_q;
	logic [STATUS_W-1:0]  m_status_q;
	logic [COUNT_W-1:0]   m_count_q;
	logic                 m_last_q;

	logic                 out_free, emit, res_last;
	logic [DATA_W-1:0]    res_data;
	status_t              res_status;

	logic                 empty, full, dump_last;
	logic [AW-1:0]        lo_n, hi_n;
	logic                 swap_more;
	logic [DATA_W-1:0]    rd_word;

	lsr_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free  = !m_valid_q || m_axis_tready;
	assign empty     = (cnt_q == '0);
	assign full      = (cnt_q >= CNT_W'(DEPTH));
	assign dump_last = ((CNT_W'(ptr_q) + 1'b1) == cnt_q);
	assign rd_word   = DATA_W'(signed'(ram_rdata));

	// shared pointer step and compare for the reversal walk
	assign lo_n      = lo_q + 1'b1;
	assign hi_n      = hi_q - 1'b1;
	assign swap_more = (lo_n < hi_n);

	assign s_axis_tready = (state_q == S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (cmd_q)
					CMD_PUSH, CMD_POP, CMD_PEEK: begin
						if (out_free) state_d = S_IDLE;
					end
					CMD_DUMP: begin
						if (!empty) state_d = S_DUMP_RD;
						else if (out_free) state_d = S_IDLE;
					end
					CMD_REVERSE: begin
						if (cnt_q > CNT_W'(1)) state_d = S_REV_A;
						else if (out_free) state_d = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_DUMP_RD:  state_d = S_DUMP_OUT;
			S_DUMP_OUT: begin
				if (out_free) state_d = dump_last ? S_IDLE : S_DUMP_RD;
			end
			S_REV_A: state_d = S_REV_B;
			S_REV_B: state_d = S_REV_C;
			S_REV_C: state_d = S_REV_D;
			S_REV_D: state_d = swap_more ? S_REV_A : S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer: ram control, result and count update
	always_comb begin
		emit       = 1'b0;
		res_data   = '0;
		res_status = ST_OK;
		res_last   = 1'b1;
		cnt_d      = cnt_q;
		ram_we     = 1'b0;
		ram_waddr  = cnt_q[AW-1:0];
		ram_wdata  = WORD_BITS'(signed'(val_q));
		ram_raddr  = AW'(cnt_q - 1'b1);
		case (state_q)
			S_EXEC: begin
				case (cmd_q)
					CMD_PUSH: begin
						emit = out_free;
						if (full) begin
							res_status = ST_OVERFLOW;
						end else begin
							ram_we = out_free;
							if (out_free) cnt_d = cnt_q + 1'b1;
						end
					end
					CMD_POP, CMD_PEEK: begin
						emit = out_free;
						if (empty) begin
							res_status = ST_EMPTY;
						end else begin
							res_data = rd_word;
							if (out_free && cmd_q == CMD_POP) cnt_d = cnt_q - 1'b1;
						end
					end
					CMD_DUMP: begin
						emit       = out_free && empty;
						res_status = ST_EMPTY;
					end
					CMD_REVERSE: begin
						emit = out_free && (cnt_q <= CNT_W'(1));
					end
					default: emit = 1'b0;
				endcase
			end
			S_DUMP_RD: ram_raddr = ptr_q;
			S_DUMP_OUT: begin
				ram_raddr = ptr_q;
				emit      = out_free;
				res_data  = rd_word;
				res_last  = dump_last;
			end
			S_REV_A: ram_raddr = lo_q;
			S_REV_B: ram_raddr = hi_q;
			S_REV_C: begin
				ram_we    = 1'b1;
				ram_waddr = lo_q;
				ram_wdata = ram_rdata;
			end
			S_REV_D: begin
				ram_we    = 1'b1;
				ram_waddr = hi_q;
				ram_wdata = tmp_q;
			end
			S_DONE: emit = out_free;
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (emit) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_q <= s_axis_tuser;
			val_q <= s_axis_tdata;
		end
		if (emit) begin
			m_data_q   <= res_data;
			m_status_q <= res_status;
			m_count_q  <= COUNT_W'(cnt_d);
			m_last_q   <= res_last;
		end
		if (state_q == S_EXEC) begin
			ptr_q <= '0;
			lo_q  <= '0;
			hi_q  <= AW'(cnt_q - 1'b1);
		end
		if (state_q == S_DUMP_OUT && emit) ptr_q <= ptr_q + 1'b1;
		if (state_q == S_REV_B) tmp_q <= ram_rdata;
		if (state_q == S_REV_D) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{M_TDATA_PAD{1'b0}}, m_count_q, m_data_q};
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tlast  = m_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REV_A || state_q == S_REV_B || state_q == S_REV_C ||
		 state_q == S_REV_D) |-> (lo_q < hi_q))
		else $error("reversal pointers crossed");

	a_dump_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP_OUT) |-> (CNT_W'(ptr_q) < cnt_q))
		else $error("dump pointer past top");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == S_EXEC && cmd_q == CMD_PUSH && !full)
		|=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("push did not grow the stack");

	a_no_emit_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_axis_tready) |-> !emit)
		else $error("result overwritten while stalled");

endmodule

>>> rtl/lsr_ram.sv
// ----------------------------------------------------------------------------
// lsr_ram: generic single-clock ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                   wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                   rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> dv/tb_lifo_stack_with_reverse_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_reverse_core: self-checking regression for the lifo core
// Drives push, pop, peek, dump, reverse and unused command codes with random
// gaps and receiver stalls. An in-bench stack model predicts every result
// beat, and each beat is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_reverse_core;
	import lsr_pkg::*;

	localparam time         CLK_HALF          = 6ns;
	localparam int          RESET_CYCLES      = 5;
	localparam int          RANDOM_ITEMS      = 75;
	localparam int          END_SETTLE_CYCLES = 300;
	// a full dump behind the longest receiver stall per beat, for every item, several times over
	localparam int unsigned CYCLE_LIMIT       = 4_000_000;

	localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

	localparam logic [VALUE_W-1:0] WORD_MAX  = 32'h7fff_ffff;
	localparam logic [VALUE_W-1:0] WORD_MIN  = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] WORD_NEG1 = 32'hffff_ffff;

	typedef struct {
		logic [DATA_W-1:0]  data_word;
		status_t            status;
		logic [COUNT_W-1:0] entry_count;
		logic               last;
	} stack_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;  // push_value[31:0]
	logic [CMD_W-1:0]     s_axis_tuser;  // command[2:0]
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;  // data_word[31:0], entry_count[38:32], zero pad
	logic [STATUS_W-1:0]  m_axis_tuser;  // status[1:0]
	logic                 m_axis_tlast;

	// stack model
	logic [VALUE_W-1:0] model_stack [DEPTH_DEF];
	int                 model_fill;
	stack_result_t      expected_results [$];

	int          n_errors      = 0;
	int unsigned cycle_count   = 0;
	int          rx_hold_cycles = 0;
	logic        no_idle       = 1'b0;

	lifo_stack_with_reverse_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("lifo_stack_with_reverse_core regression: fail");
			$finish;
		end
	end

	function automatic void queue_result(input logic [DATA_W-1:0] data_word,
			input status_t status, input logic last);
		stack_result_t r;
		r.data_word   = data_word;
		r.status      = status;
		r.entry_count = COUNT_W'(model_fill);
		r.last        = last;
		expected_results.push_back(r);
	endfunction

	// update the stack model for one accepted command and queue its result beats
	function automatic void predict_command(input logic [CMD_W-1:0] cmd,
			input logic [VALUE_W-1:0] value);
		logic [VALUE_W-1:0] top_word;
		logic [VALUE_W-1:0] tmp;
		int lo;
		int hi;
		case (cmd)
			CMD_PUSH: begin
				if (model_fill >= DEPTH_DEF) begin
					queue_result('0, ST_OVERFLOW, 1'b1);
				end else begin
					model_stack[model_fill] = value;
					model_fill++;
					queue_result('0, ST_OK, 1'b1);
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (model_fill == 0) begin
					queue_result('0, ST_EMPTY, 1'b1);
				end else begin
					top_word = model_stack[model_fill-1];
					if (cmd == CMD_POP)
						model_fill--;
					queue_result(top_word, ST_OK, 1'b1);
				end
			end
			CMD_DUMP: begin
				if (model_fill == 0)
					queue_result('0, ST_EMPTY, 1'b1);
				else
					for (int i = 0; i < model_fill; i++)
						queue_result(model_stack[i], ST_OK, i == model_fill - 1);
			end
			CMD_REVERSE: begin
				lo = 0;
				hi = model_fill - 1;
				while (lo < hi) begin
					tmp             = model_stack[lo];
					model_stack[lo] = model_stack[hi];
					model_stack[hi] = tmp;
					lo++;
					hi--;
				end
				queue_result('0, ST_OK, 1'b1);
			end
			default: ;  // unused codes leave the stack alone and give no beat
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin : result_check
		stack_result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				n_errors++;
				$display({"%0t: unexpected beat: expected none, ",
					"actual data %h count %0d status %0d last %0b"},
					$time, m_axis_tdata[DATA_W-1:0], m_axis_tdata[DATA_W +: COUNT_W],
					m_axis_tuser, m_axis_tlast);
			end else begin
				exp_r = expected_results.pop_front();
				if (m_axis_tdata[DATA_W-1:0] !== exp_r.data_word) begin
					n_errors++;
					$display("%0t: data_word mismatch: expected %h actual %h",
						$time, exp_r.data_word, m_axis_tdata[DATA_W-1:0]);
				end
				if (m_axis_tuser !== exp_r.status) begin
					n_errors++;
					$display("%0t: status mismatch: expected %0d actual %0d",
						$time, exp_r.status, m_axis_tuser);
				end
				if (m_axis_tdata[DATA_W +: COUNT_W] !== exp_r.entry_count) begin
					n_errors++;
					$display("%0t: entry_count mismatch: expected %0d actual %0d",
						$time, exp_r.entry_count, m_axis_tdata[DATA_W +: COUNT_W]);
				end
				if (m_axis_tlast !== exp_r.last) begin
					n_errors++;
					$display("%0t: last mismatch: expected %0b actual %0b",
						$time, exp_r.last, m_axis_tlast);
				end
			end
		end
	end

	// receiver ready: random stalls, a requested long hold, or always ready
	initial begin : rx_ready_gen
		int stall_left;
		int r;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold_cycles--;
			end else if (no_idle) begin
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					if (r < 92)
						stall_left = $urandom_range(0, 2);
					else if (r < 98)
						stall_left = $urandom_range(3, 8);
					else
						stall_left = $urandom_range(15, 40);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 8);
		else
			return $urandom_range(15, 40);
	endfunction

	// offer one command beat; returns at the accepting edge with tvalid still high
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= cmd;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_command(cmd, value);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_stack();
		send_cmd(CMD_POP, $urandom());
		send_cmd(CMD_PEEK, $urandom());
		send_cmd(CMD_DUMP, $urandom());
		send_cmd(CMD_REVERSE, $urandom());
	endtask

	task automatic test_basic_ops();
		send_cmd(CMD_PUSH, WORD_MAX);
		send_cmd(CMD_PEEK, $urandom());
		send_cmd(CMD_REVERSE, $urandom());  // single entry stays put
		send_cmd(CMD_PUSH, WORD_MIN);
		send_cmd(CMD_PUSH, '0);
		send_cmd(CMD_PUSH, WORD_NEG1);
		send_cmd(CMD_PUSH, 32'h0000_0001);
		send_cmd(CMD_DUMP, $urandom());
		send_cmd(CMD_REVERSE, $urandom());
		send_cmd(CMD_DUMP, $urandom());
		send_cmd(CMD_PEEK, $urandom());
		send_cmd(CMD_POP, $urandom());
		send_cmd(CMD_RSVD_5, $urandom());
		send_cmd(CMD_RSVD_6, $urandom());
		send_cmd(CMD_RSVD_7, $urandom());
		send_cmd(CMD_DUMP, $urandom());
		repeat (4) send_cmd(CMD_POP, $urandom());
		send_cmd(CMD_POP, $urandom());
	endtask

	// fill to the top behind a long receiver hold so the core backs up its input
	task automatic test_full_with_backpressure();
		wait_results_drained();
		no_idle = 1'b1;
		rx_hold_cycles = 400;
		for (int i = 0; i < DEPTH_DEF; i++)
			send_cmd(CMD_PUSH, $urandom());
		send_cmd(CMD_PUSH, $urandom());
		send_cmd(CMD_PUSH, WORD_MAX);
		send_cmd(CMD_PEEK, $urandom());
		send_cmd(CMD_REVERSE, $urandom());
		send_cmd(CMD_DUMP, $urandom());
		send_cmd(CMD_POP, $urandom());
		send_cmd(CMD_PUSH, WORD_MIN);
		send_cmd(CMD_DUMP, $urandom());
		no_idle = 1'b0;
		wait_results_drained();
	endtask

	function automatic logic [CMD_W-1:0] CMD_CODE_RSVD();
		case ($urandom_range(0, 2))
			0:       return CMD_RSVD_5;
			1:       return CMD_RSVD_6;
			default: return CMD_RSVD_7;
		endcase
	endfunction

	// phases lean toward filling, draining or a mix so the count sweeps its range
	task automatic test_random_mix(input int n_items);
		int lean;
		int r;
		int w_push;
		int w_pop;
		logic [CMD_W-1:0] cmd;
		lean = 0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 30 == 0)
				lean = $urandom_range(0, 2);
			if (i == 40)
				no_idle = 1'b1;
			if (i == 60)
				no_idle = 1'b0;
			if (i % 55 == 54)
				wait_results_drained();
			w_push = (lean == 0) ? 65 : (lean == 1) ? 20 : 40;
			w_pop  = w_push + ((lean == 1) ? 45 : 22);
			r = $urandom_range(0, 99);
			if (r < w_push)
				cmd = CMD_PUSH;
			else if (r < w_pop)
				cmd = CMD_POP;
			else if (r < w_pop + 10)
				cmd = CMD_PEEK;
			else if (r < w_pop + 16)
				cmd = CMD_DUMP;
			else if (r < w_pop + 24)
				cmd = CMD_REVERSE;
			else if (r < 100)
				cmd = CMD_CODE_RSVD();
			else
				cmd = CMD_PEEK;
			send_cmd(cmd, $urandom());
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		model_fill    = 0;
		for (int i = 0; i < DEPTH_DEF; i++)
			model_stack[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_stack();
		test_basic_ops();
		test_full_with_backpressure();
		test_random_mix(RANDOM_ITEMS);

		wait_results_drained();
		repeat (END_SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			n_errors++;
			$display("%0t: %0d result beats never arrived", $time, expected_results.size());
		end
		if (n_errors == 0)
			$display("lifo_stack_with_reverse_core regression: pass");
		else
			$display("lifo_stack_with_reverse_core regression: fail");
		$finish;
	end

endmodule
